[hdl/vgce_pkg.sv]
`timescale 1ns / 1ps
package vgce_pkg;

    localparam int DEF_SCREEN_WIDTH  = 512;
    localparam int DEF_SCREEN_HEIGHT = 256;

    typedef enum logic [1:0] {
        ACC_WRITE = 2'd0,
        ACC_READ  = 2'd1,
        ACC_TICK  = 2'd2,
        ACC_VSYNC = 2'd3
    } t_access;

    typedef enum logic [1:0] {
        RES_READ  = 2'd0,
        RES_PIXEL = 2'd1,
        RES_CLEAR = 2'd2
    } t_result;

    localparam logic [4:0] ADDR_CMD   = 5'd0;
    localparam logic [4:0] ADDR_CTRL1 = 5'd1;
    localparam logic [4:0] ADDR_CTRL2 = 5'd2;
    localparam logic [4:0] ADDR_CSIZE = 5'd3;
    localparam logic [4:0] ADDR_DX    = 5'd5;
    localparam logic [4:0] ADDR_DY    = 5'd7;
    localparam logic [4:0] ADDR_XH    = 5'd8;
    localparam logic [4:0] ADDR_XL    = 5'd9;
    localparam logic [4:0] ADDR_YH    = 5'd10;
    localparam logic [4:0] ADDR_YL    = 5'd11;
    localparam logic [4:0] ADDR_PAGE  = 5'd16;

    typedef enum logic [2:0] {
        WM_IDLE   = 3'd0,
        WM_XMAJ_UP = 3'd1,
        WM_XMAJ_DN = 3'd2,
        WM_YMAJ_UP = 3'd3,
        WM_YMAJ_DN = 3'd4
    } t_walk_mode;

    localparam logic [7:0]  STATUS_RESET = 8'h04;
    localparam logic [7:0]  CSIZE_RESET  = 8'h11;
    localparam logic [15:0] MASK_START   = 16'h8000;

    // Line start request from the command decoder to the walker.
    typedef struct packed {
        logic        start;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [8:0]  dx;
        logic [8:0]  dy;
        logic        up;
    } t_walk_req;

    typedef struct packed {
        logic       valid;
        t_result    kind;
        logic [7:0] value;
        logic [8:0] x;
        logic [7:0] y;
        logic       ink;
        logic [1:0] page;
    } t_result_word;

    function automatic logic [15:0] style_pattern(input logic [1:0] sel);
        case (sel)
            2'd0:    style_pattern = 16'hFFFF;
            2'd1:    style_pattern = 16'hCCCC;
            2'd2:    style_pattern = 16'hF0F0;
            default: style_pattern = 16'hFFCC;
        endcase
    endfunction

endpackage

[hdl/vector_graphics_command_engine.sv]
`timescale 1ns / 1ps
// Channel | direction | handshake
// in      | input     | i_valid / o_stall  (access_kind, reg_addr, write_data)
// out     | output    | o_valid / i_stall  (result_kind .. pixel_page)
// One word is taken per cycle while o_stall is low; each result appears in the cycle after its input word.
// The output register is the only holding stage: input stalls only while it holds
// an untaken result and the downstream side stalls.
// Reset (i_rst_n low, synchronous) restores all registers of this module and idles the walker.
module vector_graphics_command_engine
    import vgce_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_access_kind,
    input  logic [4:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_read_value,
    output logic [8:0] o_pixel_x,
    output logic [7:0] o_pixel_y,
    output logic       o_pixel_ink,
    output logic [1:0] o_pixel_page
);
    logic [7:0]  r_status, r_ctrl1, r_ctrl2, r_csize, r_dx, r_dy, r_page;
    logic [15:0] r_pen_x, r_pen_y;
    logic [7:0]  n_status, n_ctrl1, n_ctrl2, n_csize, n_dx, n_dy, n_page;
    logic [15:0] n_pen_x, n_pen_y;
    t_result_word r_out, n_out;
    t_walk_req    req;

    logic        acc, busy, done, w_emit, w_ink, wr, is_tick;
    logic [8:0]  w_x;
    logic [7:0]  w_y;
    t_access     kind;

    assign o_stall = r_out.valid && i_stall;
    assign acc     = i_valid && !o_stall;
    assign kind    = t_access'(i_access_kind);
    assign wr      = acc && (kind == ACC_WRITE) && !busy;
    assign is_tick = acc && (kind == ACC_TICK);

    vgce_walker #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_walker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .i_tick(is_tick),
        .i_style(r_ctrl2[1:0]), .i_pen_ink(r_ctrl1[1]),
        .o_busy(busy), .o_done(done), .o_emit(w_emit),
        .o_x(w_x), .o_y(w_y), .o_ink(w_ink)
    );

    // Line helper: sign of x/y step (-1,0,+1) and magnitudes.
    logic        ln_go, ln_v;
    logic [1:0]  ln_sx, ln_sy;   // 0 none, 1 plus, 2 minus
    logic [7:0]  ln_ddx, ln_ddy;
    logic [15:0] ex, ey;
    logic [2:0]  dir;
    logic [4:0]  cw;
    logic [7:0]  adv;

    assign dir = i_write_data[2:0];
    assign cw  = (r_csize[7:4] == 4'd0) ? 5'd16 : {1'b0, r_csize[7:4]};
    assign adv = {3'd0, cw} * 8'd6;

    always_comb begin
        ln_go = 1'b0; ln_v = 1'b0; ln_sx = 2'd0; ln_sy = 2'd0;
        ln_ddx = r_dx; ln_ddy = r_dy;
        if (i_write_data[7]) begin
            ln_go = 1'b1;
            ln_ddx = {6'd0, i_write_data[6:5]};
            ln_ddy = {6'd0, i_write_data[4:3]};
            case (dir)
                3'd0: begin ln_sx = 2'd1; ln_sy = 2'd0; end
                3'd1: begin ln_sx = 2'd1; ln_sy = 2'd1; end
                3'd2: begin ln_sx = 2'd0; ln_sy = 2'd1; end
                3'd3: begin ln_sx = 2'd2; ln_sy = 2'd1; end
                3'd4: begin ln_sx = 2'd0; ln_sy = 2'd2; end
                3'd5: begin ln_sx = 2'd1; ln_sy = 2'd2; end
                3'd6: begin ln_sx = 2'd2; ln_sy = 2'd0; end
                default: begin ln_sx = 2'd2; ln_sy = 2'd2; end
            endcase
        end else begin
            case (i_write_data)
                8'd16: begin ln_go = 1'b1; ln_sx = 2'd1; end
                8'd17: begin ln_go = 1'b1; ln_sx = 2'd1; ln_sy = 2'd1; end
                8'd18: begin ln_go = 1'b1; ln_v = 1'b1; ln_sy = 2'd1; end
                8'd19: begin ln_go = 1'b1; ln_sx = 2'd2; ln_sy = 2'd1; end
                8'd20: begin ln_go = 1'b1; ln_v = 1'b1; ln_sy = 2'd2; end
                8'd21: begin ln_go = 1'b1; ln_sx = 2'd1; ln_sy = 2'd2; end
                8'd22: begin ln_go = 1'b1; ln_sx = 2'd2; end
                8'd23: begin ln_go = 1'b1; ln_sx = 2'd2; ln_sy = 2'd2; end
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [8:0] ldx, ldy;
        logic       swap, dpos, dneg;
        ex = (ln_sx == 2'd1) ? r_pen_x + {8'd0, ln_ddx} :
             (ln_sx == 2'd2) ? r_pen_x - {8'd0, ln_ddx} : r_pen_x;
        ey = (ln_sy == 2'd1) ? r_pen_y + {8'd0, ln_ddy} :
             (ln_sy == 2'd2) ? r_pen_y - {8'd0, ln_ddy} : r_pen_y;
        ldx = (ln_sx != 2'd0) ? {1'b0, ln_ddx} : 9'd0;
        ldy = (ln_sy != 2'd0) ? {1'b0, ln_ddy} : 9'd0;
        swap = (ln_sx == 2'd2) && (ldx != 9'd0);
        dpos = (ldy != 9'd0) && (ln_sy == 2'd1);
        dneg = (ldy != 9'd0) && (ln_sy == 2'd2);
        req = '0;
        req.start = wr && (i_reg_addr == ADDR_CMD) && ln_go && r_ctrl1[0];
        if (ln_v) begin
            req.sx = r_pen_x;
            req.sy = (ln_sy == 2'd1) ? ey : r_pen_y;
            req.dx = 9'd0;
            req.dy = {1'b0, ln_ddy};
            req.up = 1'b0;
        end else begin
            req.sx = swap ? ex : r_pen_x;
            req.sy = swap ? ey : r_pen_y;
            req.dx = ldx;
            req.dy = ldy;
            req.up = swap ? dneg : dpos;
        end
    end

    always_comb begin
        n_status = r_status; n_ctrl1 = r_ctrl1; n_ctrl2 = r_ctrl2; n_csize = r_csize;
        n_dx = r_dx; n_dy = r_dy; n_page = r_page; n_pen_x = r_pen_x; n_pen_y = r_pen_y;
        n_out = r_out;
        if (!o_stall) n_out.valid = 1'b0;
        if (req.start) n_status[2] = 1'b0;
        if (done) n_status[2] = 1'b1;
        if (acc) begin
            case (kind)
                ACC_READ: begin
                    n_out = '0;
                    n_out.valid = 1'b1;
                    n_out.kind  = RES_READ;
                    case (i_reg_addr)
                        ADDR_CMD:   n_out.value = r_status;
                        ADDR_CTRL1: n_out.value = r_ctrl1;
                        ADDR_CTRL2: n_out.value = r_ctrl2;
                        ADDR_CSIZE: n_out.value = r_csize;
                        ADDR_DX:    n_out.value = r_dx;
                        ADDR_DY:    n_out.value = r_dy;
                        ADDR_XH:    n_out.value = r_pen_x[15:8];
                        ADDR_XL:    n_out.value = r_pen_x[7:0];
                        ADDR_YH:    n_out.value = r_pen_y[15:8];
                        ADDR_YL:    n_out.value = r_pen_y[7:0];
                        ADDR_PAGE:  n_out.value = r_page;
                        default:    n_out.value = 8'd0;
                    endcase
                end
                ACC_TICK: begin
                    if (w_emit) begin
                        n_out = '0;
                        n_out.valid = 1'b1;
                        n_out.kind  = RES_PIXEL;
                        n_out.x = w_x; n_out.y = w_y; n_out.ink = w_ink;
                        n_out.page = r_page[7:6];
                    end
                end
                ACC_VSYNC: n_status[1] = i_write_data[0];
                default: begin
                    if (!busy) begin
                        case (i_reg_addr)
                            ADDR_CMD: begin
                                if (ln_go) begin
                                    n_pen_x = ln_v ? r_pen_x : ex;
                                    n_pen_y = ey;
                                end else if ((i_write_data[6:5] != 2'd0) ||
                                             (i_write_data == 8'd10)) begin
                                    if (r_ctrl2[3]) n_pen_y = r_pen_y + {8'd0, adv};
                                    else n_pen_x = r_pen_x + {8'd0, adv};
                                end else begin
                                    case (i_write_data)
                                        8'd0: n_ctrl1[1] = 1'b1;
                                        8'd1: n_ctrl1[1] = 1'b0;
                                        8'd2: n_ctrl1[0] = 1'b1;
                                        8'd3: n_ctrl1[0] = 1'b0;
                                        8'd5: begin n_pen_x = '0; n_pen_y = '0; end
                                        8'd13: n_pen_x = '0;
                                        8'd14: n_pen_y = '0;
                                        default: ;
                                    endcase
                                    if (i_write_data == 8'd4 || i_write_data == 8'd6 ||
                                        i_write_data == 8'd7) begin
                                        n_out = '0;
                                        n_out.valid = 1'b1;
                                        n_out.kind  = RES_CLEAR;
                                        n_out.page  = r_page[7:6];
                                    end
                                    if (i_write_data == 8'd6) begin
                                        n_pen_x = '0; n_pen_y = '0;
                                    end
                                    if (i_write_data == 8'd7) begin
                                        n_pen_x = '0; n_pen_y = '0;
                                        n_csize = CSIZE_RESET; n_ctrl1 = '0;
                                        n_status = STATUS_RESET;
                                    end
                                end
                            end
                            ADDR_CTRL1: n_ctrl1 = i_write_data;
                            ADDR_CTRL2: n_ctrl2 = i_write_data;
                            ADDR_CSIZE: n_csize = i_write_data;
                            ADDR_DX:    n_dx = i_write_data;
                            ADDR_DY:    n_dy = i_write_data;
                            ADDR_XH:    n_pen_x[15:8] = i_write_data;
                            ADDR_XL:    n_pen_x[7:0] = i_write_data;
                            ADDR_YH:    n_pen_y[15:8] = i_write_data;
                            ADDR_YL:    n_pen_y[7:0] = i_write_data;
                            ADDR_PAGE:  n_page = i_write_data;
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= STATUS_RESET; r_ctrl1 <= '0; r_ctrl2 <= '0;
            r_csize <= CSIZE_RESET; r_dx <= '0; r_dy <= '0; r_page <= '0;
            r_pen_x <= '0; r_pen_y <= '0;
            r_out <= '0;
        end else begin
            r_status <= n_status; r_ctrl1 <= n_ctrl1; r_ctrl2 <= n_ctrl2;
            r_csize <= n_csize; r_dx <= n_dx; r_dy <= n_dy; r_page <= n_page;
            r_pen_x <= n_pen_x; r_pen_y <= n_pen_y;
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out.valid;
    assign o_result_kind = r_out.kind;
    assign o_read_value  = r_out.value;
    assign o_pixel_x     = r_out.x;
    assign o_pixel_y     = r_out.y;
    assign o_pixel_ink   = r_out.ink;
    assign o_pixel_page  = r_out.page;
endmodule

[hdl/vgce_walker.sv]
`timescale 1ns / 1ps
module vgce_walker
    import vgce_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_walk_req  i_req,
    input  logic       i_tick,
    input  logic [1:0] i_style,
    input  logic       i_pen_ink,
    output logic       o_busy,
    output logic       o_done,
    output logic       o_emit,
    output logic [8:0] o_x,
    output logic [7:0] o_y,
    output logic       o_ink
);
    localparam logic [16:0] W_LIM = 17'(SCREEN_WIDTH);
    localparam logic [16:0] H_LIM = 17'(SCREEN_HEIGHT);
    localparam logic [15:0] H_TOP = 16'(SCREEN_HEIGHT - 1);

    t_walk_mode  r_mode, n_mode;
    logic [15:0] r_x, n_x, r_y, n_y;
    logic [8:0]  r_end, n_end, r_dx, n_dx, r_dy, n_dy;
    logic signed [11:0] r_err, n_err;
    logic [15:0] r_mask, n_mask;

    logic        xmaj, up, on_style;
    logic [15:0] y_step;

    assign o_busy = (r_mode != WM_IDLE);
    assign xmaj   = (r_mode == WM_XMAJ_UP) || (r_mode == WM_XMAJ_DN);
    assign up     = (r_mode == WM_XMAJ_UP) || (r_mode == WM_YMAJ_UP);
    assign y_step = up ? r_y + 16'd1 : r_y - 16'd1;
    assign on_style = |(style_pattern(i_style) & r_mask);
    assign o_ink  = on_style ? i_pen_ink : ~i_pen_ink;
    assign o_done = i_tick && o_busy && (r_end == 9'd0);
    assign o_emit = i_tick && o_busy && ({1'b0, r_x} < W_LIM) && ({1'b0, r_y} < H_LIM);
    assign o_x    = r_x[8:0];
    assign o_y    = 8'(H_TOP - r_y);

    always_comb begin
        n_mode = r_mode; n_x = r_x; n_y = r_y; n_end = r_end;
        n_dx = r_dx; n_dy = r_dy; n_err = r_err; n_mask = r_mask;
        if (i_req.start) begin
            n_x = i_req.sx; n_y = i_req.sy;
            n_dx = i_req.dx; n_dy = i_req.dy;
            n_mask = MASK_START;
            if (i_req.dx > i_req.dy) begin
                n_mode = i_req.up ? WM_XMAJ_UP : WM_XMAJ_DN;
                n_err = 12'(({3'b0, i_req.dy} << 1)) - 12'({3'b0, i_req.dx});
                n_end = i_req.dx;
            end else begin
                n_mode = i_req.up ? WM_YMAJ_UP : WM_YMAJ_DN;
                n_err = 12'(({3'b0, i_req.dx} << 1)) - 12'({3'b0, i_req.dy});
                n_end = i_req.dy;
            end
        end else if (i_tick && o_busy) begin
            n_mask = (r_mask == 16'd1) ? MASK_START : (r_mask >> 1);
            if (r_end == 9'd0) begin
                n_mode = WM_IDLE;
            end else begin
                n_end = r_end - 9'd1;
                if (xmaj) begin
                    n_x = r_x + 16'd1;
                    if (r_err[11]) begin
                        n_err = r_err + 12'({r_dy, 1'b0});
                    end else begin
                        n_y = y_step;
                        n_err = r_err + 12'({r_dy, 1'b0}) - 12'({r_dx, 1'b0});
                    end
                end else begin
                    n_y = y_step;
                    if (r_err[11]) begin
                        n_err = r_err + 12'({r_dx, 1'b0});
                    end else begin
                        n_x = r_x + 16'd1;
                        n_err = r_err + 12'({r_dx, 1'b0}) - 12'({r_dy, 1'b0});
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= WM_IDLE;
            r_mask <= MASK_START;
        end else begin
            r_mode <= n_mode;
            r_mask <= n_mask;
        end
        r_x <= n_x; r_y <= n_y; r_end <= n_end;
        r_dx <= n_dx; r_dy <= n_dy; r_err <= n_err;
    end
endmodule

[hdl/vgce_checker.sv]
`timescale 1ns / 1ps
module vgce_checker
    import vgce_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_access_kind,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_result_kind,
    input logic [7:0] o_read_value,
    input logic       o_pixel_ink,
    input logic [1:0] o_pixel_page
);
    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_access_kind == ACC_READ) |=> o_valid)
        else $error("read produced no word");
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_kind == RES_READ || o_result_kind == RES_PIXEL ||
                     o_result_kind == RES_CLEAR))
        else $error("bad result kind");
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == RES_READ) |-> (o_pixel_page == 2'd0 && !o_pixel_ink))
        else $error("read word carries pixel fields");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_value)))
        else $error("stalled word changed");
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output stall");
endmodule

bind vector_graphics_command_engine vgce_checker u_vgce_checker (.*);

[verif/vector_graphics_command_engine_chk.sv]
`timescale 1ns / 1ps
module vector_graphics_command_engine_chk
    import vgce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_access_kind,
    input  logic [4:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_result_kind,
    input  logic [7:0] i_read_value,
    input  logic [8:0] i_pixel_x,
    input  logic [7:0] i_pixel_y,
    input  logic       i_pixel_ink,
    input  logic [1:0] i_pixel_page,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_pixel_count,
    output int         o_clear_count,
    output int         o_read_count
);

    typedef struct packed {
        t_result    kind;
        logic [7:0] value;
        logic [8:0] x;
        logic [7:0] y;
        logic       ink;
        logic [1:0] page;
    } t_drawn;

    t_drawn drawn_q[$];

    logic [7:0]  status_r, ctrl1_r, ctrl2_r, csize_r, dx_r, dy_r, page_r;
    logic [15:0] pen_x, pen_y, walk_x, walk_y, style_bits;
    int          steps_left, err_acc, span_x, span_y;
    t_walk_mode  walk_mode;

    int vec_step_x[8] = '{1, 1, 0, -1, 0, 1, -1, -1};
    int vec_step_y[8] = '{0, 1, 1, 1, -1, -1, 0, -1};

    function automatic logic [15:0] nudge(logic [15:0] v, int dir, int d);
        if (dir > 0) return v + d[15:0];
        if (dir < 0) return v - d[15:0];
        return v;
    endfunction

    function automatic bit walking();
        return walk_mode != WM_IDLE;
    endfunction

    task automatic push_drawn(t_result k, logic [7:0] v, logic [8:0] x, logic [7:0] y,
                              logic ink, logic [1:0] pg);
        t_drawn w;
        w.kind = k; w.value = v; w.x = x; w.y = y; w.ink = ink; w.page = pg;
        drawn_q.push_back(w);
    endtask

    task automatic begin_walk(logic [15:0] sx, logic [15:0] sy, int dx, int dy, bit up);
        walk_x = sx;
        walk_y = sy;
        span_x = dx;
        span_y = dy;
        style_bits = MASK_START;
        if (dx > dy) begin
            walk_mode = up ? WM_XMAJ_UP : WM_XMAJ_DN;
            err_acc = 2 * dy - dx;
            steps_left = dx;
        end else begin
            walk_mode = up ? WM_YMAJ_UP : WM_YMAJ_DN;
            err_acc = 2 * dx - dy;
            steps_left = dy;
        end
        status_r[2] = 1'b0;
    endtask

    task automatic draw_span(int sxs, int ddx, int sys, int ddy);
        logic [15:0] ex, ey;
        int dx, dy, disp;
        ex = nudge(pen_x, sxs, ddx);
        ey = nudge(pen_y, sys, ddy);
        dx = (sxs != 0) ? ddx : 0;
        dy = (sys != 0) ? ddy : 0;
        if (ctrl1_r[0]) begin
            disp = (dy > 0) ? sys : 0;
            // walk from the far end when x decreases
            if (sxs < 0 && dx > 0) begin_walk(ex, ey, dx, dy, -disp > 0);
            else begin_walk(pen_x, pen_y, dx, dy, disp > 0);
        end
        pen_x = ex;
        pen_y = ey;
    endtask

    task automatic draw_vertical(int sys, int d);
        logic [15:0] ey;
        ey = nudge(pen_y, sys, d);
        if (ctrl1_r[0]) begin_walk(pen_x, sys > 0 ? ey : pen_y, 0, d, 1'b0);
        pen_y = ey;
    endtask

    task automatic advance_char();
        int w;
        w = (csize_r[7:4] == 0) ? 16 : csize_r[7:4];
        if (ctrl2_r[3]) pen_y = pen_y + 16'(6 * w);
        else pen_x = pen_x + 16'(6 * w);
    endtask

    task automatic run_command(logic [7:0] b);
        if (b >= 8'h20 && b <= 8'h7F) begin
            advance_char();
        end else if (b[7]) begin
            draw_span(vec_step_x[b[2:0]], b[6:5], vec_step_y[b[2:0]], b[4:3]);
        end else begin
            case (b)
                8'd0: ctrl1_r[1] = 1'b1;
                8'd1: ctrl1_r[1] = 1'b0;
                8'd2: ctrl1_r[0] = 1'b1;
                8'd3: ctrl1_r[0] = 1'b0;
                8'd4: push_drawn(RES_CLEAR, 0, 0, 0, 0, page_r[7:6]);
                8'd5: begin pen_x = 0; pen_y = 0; end
                8'd6: begin
                    push_drawn(RES_CLEAR, 0, 0, 0, 0, page_r[7:6]);
                    pen_x = 0; pen_y = 0;
                end
                8'd7: begin
                    push_drawn(RES_CLEAR, 0, 0, 0, 0, page_r[7:6]);
                    pen_x = 0; pen_y = 0; csize_r = CSIZE_RESET; ctrl1_r = 0;
                    status_r = STATUS_RESET;
                end
                8'd10: advance_char();
                8'd13: pen_x = 0;
                8'd14: pen_y = 0;
                8'd16: draw_span(1, dx_r, 0, 0);
                8'd17: draw_span(1, dx_r, 1, dy_r);
                8'd18: draw_vertical(1, dy_r);
                8'd19: draw_span(-1, dx_r, 1, dy_r);
                8'd20: draw_vertical(-1, dy_r);
                8'd21: draw_span(1, dx_r, -1, dy_r);
                8'd22: draw_span(-1, dx_r, 0, 0);
                8'd23: draw_span(-1, dx_r, -1, dy_r);
                default: ;
            endcase
        end
    endtask

    function automatic logic [7:0] reg_value(logic [4:0] a);
        case (a)
            ADDR_CMD:   return status_r;
            ADDR_CTRL1: return ctrl1_r;
            ADDR_CTRL2: return ctrl2_r;
            ADDR_CSIZE: return csize_r;
            ADDR_DX:    return dx_r;
            ADDR_DY:    return dy_r;
            ADDR_XH:    return pen_x[15:8];
            ADDR_XL:    return pen_x[7:0];
            ADDR_YH:    return pen_y[15:8];
            ADDR_YL:    return pen_y[7:0];
            ADDR_PAGE:  return page_r;
            default:    return 8'h00;
        endcase
    endfunction

    task automatic write_reg(logic [4:0] a, logic [7:0] b);
        case (a)
            ADDR_CMD:   run_command(b);
            ADDR_CTRL1: ctrl1_r = b;
            ADDR_CTRL2: ctrl2_r = b;
            ADDR_CSIZE: csize_r = b;
            ADDR_DX:    dx_r = b;
            ADDR_DY:    dy_r = b;
            ADDR_XH:    pen_x[15:8] = b;
            ADDR_XL:    pen_x[7:0] = b;
            ADDR_YH:    pen_y[15:8] = b;
            ADDR_YL:    pen_y[7:0] = b;
            ADDR_PAGE:  page_r = b;
            default: ;
        endcase
    endtask

    task automatic plot_step();
        logic [15:0] x, y;
        logic ink;
        bit y_up;
        x = walk_x;
        y = walk_y;
        ink = ((style_pattern(ctrl2_r[1:0]) & style_bits) != 0) ? ctrl1_r[1] : ~ctrl1_r[1];
        style_bits = (style_bits == 16'h0001) ? MASK_START : style_bits >> 1;
        y_up = (walk_mode == WM_XMAJ_UP || walk_mode == WM_YMAJ_UP);
        if (steps_left == 0) begin
            walk_mode = WM_IDLE;
            status_r[2] = 1'b1;
        end else begin
            steps_left--;
            if (walk_mode == WM_XMAJ_UP || walk_mode == WM_XMAJ_DN) begin
                walk_x = walk_x + 1;
                if (err_acc < 0) begin
                    err_acc += 2 * span_y;
                end else begin
                    walk_y = y_up ? walk_y + 1 : walk_y - 1;
                    err_acc += 2 * (span_y - span_x);
                end
            end else begin
                walk_y = y_up ? walk_y + 1 : walk_y - 1;
                if (err_acc < 0) begin
                    err_acc += 2 * span_x;
                end else begin
                    walk_x = walk_x + 1;
                    err_acc += 2 * (span_x - span_y);
                end
            end
        end
        // drop off-screen pixels; the step and style bit are still spent
        if (x < DEF_SCREEN_WIDTH && y < DEF_SCREEN_HEIGHT)
            push_drawn(RES_PIXEL, 0, x[8:0], 8'(DEF_SCREEN_HEIGHT - 1 - y), ink, page_r[7:6]);
    endtask

    task automatic take_word(logic [1:0] k, logic [4:0] a, logic [7:0] d);
        case (k)
            ACC_WRITE: if (!walking()) write_reg(a, d);
            ACC_READ:  push_drawn(RES_READ, reg_value(a), 0, 0, 0, 0);
            ACC_TICK:  if (walking()) plot_step();
            default:   status_r[1] = d[0];
        endcase
    endtask

    task automatic reset_model();
        status_r = STATUS_RESET; ctrl1_r = 0; ctrl2_r = 0; csize_r = CSIZE_RESET;
        dx_r = 0; dy_r = 0; page_r = 0; pen_x = 0; pen_y = 0;
        walk_x = 0; walk_y = 0; steps_left = 0; err_acc = 0; span_x = 0; span_y = 0;
        walk_mode = WM_IDLE; style_bits = MASK_START;
        drawn_q.delete();
    endtask

    task automatic compare_word();
        t_drawn w;
        bit bad;
        if (drawn_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: unexpected word kind=%0d value=%02h x=%0d y=%0d ink=%0d page=%0d",
                         $realtime, i_result_kind, i_read_value, i_pixel_x, i_pixel_y,
                         i_pixel_ink, i_pixel_page);
            return;
        end
        w = drawn_q.pop_front();
        bad = (w.kind != i_result_kind) || (w.value != i_read_value) || (w.x != i_pixel_x)
            || (w.y != i_pixel_y) || (w.ink != i_pixel_ink) || (w.page != i_pixel_page);
        if (bad) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: mismatch exp kind=%0d value=%02h x=%0d y=%0d ink=%0d page=%0d %s",
                         $realtime, w.kind, w.value, w.x, w.y, w.ink, w.page,
                         $sformatf("got kind=%0d value=%02h x=%0d y=%0d ink=%0d page=%0d",
                                   i_result_kind, i_read_value, i_pixel_x, i_pixel_y,
                                   i_pixel_ink, i_pixel_page));
        end
        case (w.kind)
            RES_PIXEL: o_pixel_count++;
            RES_CLEAR: o_clear_count++;
            default:   o_read_count++;
        endcase
    endtask

    initial begin
        o_fail_count = 0;
        o_pixel_count = 0;
        o_clear_count = 0;
        o_read_count = 0;
        reset_model();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && !i_out_stall) compare_word();
            if (i_in_valid && !i_in_stall) take_word(i_access_kind, i_reg_addr, i_write_data);
        end
        o_pending = drawn_q.size();
    end

endmodule

[verif/vector_graphics_command_engine_tb.sv]
`timescale 1ns / 1ps
module vector_graphics_command_engine_tb;
    import vgce_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_access_kind;
    logic [4:0] i_reg_addr;
    logic [7:0] i_write_data;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_result_kind;
    logic [7:0] o_read_value;
    logic [8:0] o_pixel_x;
    logic [7:0] o_pixel_y;
    logic       o_pixel_ink;
    logic [1:0] o_pixel_page;

    int fail_count, pending, pixel_count, clear_count, read_count;
    int words_sent;
    int cycle_count;
    bit calm;

    vector_graphics_command_engine DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_access_kind(i_access_kind), .i_reg_addr(i_reg_addr), .i_write_data(i_write_data),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_kind(o_result_kind), .o_read_value(o_read_value),
        .o_pixel_x(o_pixel_x), .o_pixel_y(o_pixel_y),
        .o_pixel_ink(o_pixel_ink), .o_pixel_page(o_pixel_page)
    );

    vector_graphics_command_engine_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_access_kind(i_access_kind), .i_reg_addr(i_reg_addr), .i_write_data(i_write_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_result_kind(o_result_kind), .i_read_value(o_read_value),
        .i_pixel_x(o_pixel_x), .i_pixel_y(o_pixel_y),
        .i_pixel_ink(o_pixel_ink), .i_pixel_page(o_pixel_page),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_pixel_count(pixel_count), .o_clear_count(clear_count), .o_read_count(read_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= !calm && ($urandom_range(99) < 18);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still awaited", cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // valid stays high after a word; the next call either idles or replaces the payload
    task automatic send_word(t_access k, logic [4:0] a, logic [7:0] d);
        bit held;
        while (!calm && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_access_kind <= k;
        i_reg_addr <= a;
        i_write_data <= d;
        do begin
            #1;
            held = o_stall;
            @(posedge i_clk);
            if (held) @(negedge i_clk);
        end while (held);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic tick_line(int n);
        repeat (n) send_word(ACC_TICK, 0, 0);
    endtask

    // pen down, load deltas and a start point, draw, and spend ticks on it
    task automatic draw_random_line();
        int dx, dy;
        logic [7:0] cmd;
        dx = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
        dy = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
        send_word(ACC_WRITE, ADDR_CTRL1, 8'($urandom_range(255)) | 8'h01);
        if ($urandom_range(2) == 0) send_word(ACC_WRITE, ADDR_CTRL2, 8'($urandom_range(255)));
        if ($urandom_range(3) == 0) send_word(ACC_WRITE, ADDR_PAGE, 8'($urandom_range(255)));
        send_word(ACC_WRITE, ADDR_DX, 8'(dx));
        send_word(ACC_WRITE, ADDR_DY, 8'(dy));
        send_word(ACC_WRITE, ADDR_XH, ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                                : 8'($urandom_range(1)));
        send_word(ACC_WRITE, ADDR_XL, 8'($urandom_range(255)));
        send_word(ACC_WRITE, ADDR_YH, ($urandom_range(9) == 0) ? 8'hFF : 8'h00);
        send_word(ACC_WRITE, ADDR_YL, 8'($urandom_range(255)));
        if ($urandom_range(3) == 0) cmd = 8'h80 | 8'($urandom_range(127));
        else cmd = 8'(16 + $urandom_range(7));
        send_word(ACC_WRITE, ADDR_CMD, cmd);
        repeat ($urandom_range(2, 0) + ((dx > dy ? dx : dy) > 20 ? 1 : dx + dy + 2)) begin
            case ($urandom_range(9))
                0: send_word(ACC_READ, 5'($urandom_range(16)), 0);
                1: send_word(ACC_WRITE, 5'($urandom_range(31)), 8'($urandom_range(255)));
                2: send_word(ACC_VSYNC, 0, 8'($urandom_range(255)));
                default: send_word(ACC_TICK, 0, 0);
            endcase
        end
        // finish long lines without spending too many items
        if ((dx > dy ? dx : dy) > 20) tick_line(257);
        send_word(ACC_READ, ADDR_CMD, 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_access_kind = ACC_WRITE;
        i_reg_addr = '0;
        i_write_data = '0;
        i_stall = 1'b0;
        cycle_count = 0;
        words_sent = 0;
        calm = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values, unmapped reads, vsync level
        send_word(ACC_READ, ADDR_CMD, 0);
        send_word(ACC_READ, ADDR_CSIZE, 0);
        send_word(ACC_READ, 5'd31, 0);
        send_word(ACC_VSYNC, 0, 8'hFF);
        send_word(ACC_READ, ADDR_CMD, 0);
        send_word(ACC_WRITE, 5'd4, 8'hFF);
        send_word(ACC_TICK, 0, 0);
        // pen up line only moves the pen; characters advance it
        send_word(ACC_WRITE, ADDR_DX, 8'hFF);
        send_word(ACC_WRITE, ADDR_CMD, 8'd16);
        send_word(ACC_WRITE, ADDR_CMD, 8'h7F);
        send_word(ACC_WRITE, ADDR_CSIZE, 8'h00);
        send_word(ACC_WRITE, ADDR_CMD, 8'd10);
        send_word(ACC_READ, ADDR_XL, 0);
        send_word(ACC_WRITE, ADDR_CMD, 8'd4);
        send_word(ACC_WRITE, ADDR_CMD, 8'd7);
        // pen down in foreground, short vector, busy write dropped
        send_word(ACC_WRITE, ADDR_CMD, 8'd0);
        send_word(ACC_WRITE, ADDR_CMD, 8'd2);
        send_word(ACC_WRITE, ADDR_CMD, 8'hFF);
        send_word(ACC_WRITE, ADDR_PAGE, 8'hC0);
        tick_line(4);
        // line that wraps below zero and stays off screen
        send_word(ACC_WRITE, ADDR_DY, 8'h03);
        send_word(ACC_WRITE, ADDR_CMD, 8'd20);
        tick_line(5);
        send_word(ACC_WRITE, ADDR_CMD, 8'd6);

        while (words_sent < 575) begin
            calm = (words_sent > 250 && words_sent < 400);
            if ($urandom_range(4) == 0) begin
                case ($urandom_range(3))
                    0: send_word(ACC_WRITE, 5'($urandom_range(31)), 8'($urandom_range(255)));
                    1: send_word(ACC_WRITE, ADDR_CMD, 8'($urandom_range(255)));
                    2: send_word(ACC_READ, 5'($urandom_range(31)), 0);
                    default: send_word(t_access'($urandom_range(3)), 5'($urandom_range(31)),
                                       8'($urandom_range(255)));
                endcase
            end else begin
                draw_random_line();
            end
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("sent %0d words; checked %0d pixels, %0d clears, %0d reads",
                 words_sent, pixel_count, clear_count, read_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d words missing", fail_count, pending);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
